>>> design/bmprle4_pkg.sv
`default_nettype none
package bmprle4_pkg;

   localparam int CFG_WIDTH   = 15;
   localparam int CSR_IDX_W   = 2;
   localparam int COORD_W     = 15;
   localparam int SPAN_W      = 14;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_COUNT = 3'd0,
      PH_VALUE = 3'd1,
      PH_DX    = 3'd2,
      PH_DY    = 3'd3,
      PH_ABS   = 3'd4,
      PH_PAD   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_SPAN   = 2'd0,
      KIND_END    = 2'd1,
      KIND_BOUNDS = 2'd2,
      KIND_TRUNC  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_first;
      logic       in_last;
   } req_item_type;

   typedef struct packed {
      kind_type          result_kind;
      logic [SPAN_W-1:0] span_x;
      logic [SPAN_W-1:0] span_y;
      logic [7:0]        span_length;
      logic [3:0]        even_nibble;
      logic [3:0]        odd_nibble;
   } rsp_item_type;

   typedef struct packed {
      phase_type          phase;
      logic [COORD_W-1:0] cursor_x;
      logic [COORD_W-1:0] cursor_y;
      logic [7:0]         held_count;
      logic [7:0]         pixels_left;
      logic               pad_pending;
      logic [7:0]         held_dx;
      logic               stopped;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:       PH_COUNT,
      cursor_x:    '0,
      cursor_y:    '0,
      held_count:  '0,
      pixels_left: '0,
      pad_pending: 1'b0,
      held_dx:     '0,
      stopped:     1'b0
   };

   localparam logic [CFG_WIDTH-1:0] WIDTH_RESET  = 15'd16;
   localparam logic [CFG_WIDTH-1:0] HEIGHT_RESET = 15'd16;

endpackage
`default_nettype wire

>>> design/bmprle4_step.sv
`default_nettype none
module bmprle4_step #(
   parameter int MAX_SIDE = 16384
) (
   input  wire bmprle4_pkg::state_type                      state_i,
   input  wire logic [bmprle4_pkg::CFG_WIDTH-1:0]           width_i,
   input  wire logic [bmprle4_pkg::CFG_WIDTH-1:0]           height_i,
   input  wire bmprle4_pkg::req_item_type                   item_i,
   output bmprle4_pkg::state_type                           state_o,
   output logic                                             res_valid_o,
   output bmprle4_pkg::rsp_item_type                        res_o
);

   localparam logic [bmprle4_pkg::CFG_WIDTH-1:0] SIDE_MAX = 15'(MAX_SIDE);

   bmprle4_pkg::state_type cur;
   bmprle4_pkg::state_type nxt;
   logic       bad_geom;
   logic       is_span;
   logic       is_end;
   logic       is_bounds;
   logic [1:0] abs_n;
   logic [7:0] span_len;
   logic [15:0] run_end;
   logic [15:0] dx_end;
   logic [15:0] esc_end;
   logic [15:0] dy_end;
   logic [14:0] ylim;
   logic [8:0]  b_plus;
   logic        y_out;
   logic [7:0]  b;

   always_comb begin
      cur = item_i.in_first ? bmprle4_pkg::STATE_RESET : state_i;
      nxt = cur;
      b = item_i.in_byte;
      bad_geom = (width_i == '0) || (height_i == '0) ||
                 (width_i > SIDE_MAX) || (height_i > SIDE_MAX);
      is_span = 1'b0;
      is_end = 1'b0;
      is_bounds = 1'b0;
      span_len = '0;
      y_out = (cur.cursor_y >= height_i);
      run_end = {1'b0, cur.cursor_x} + 16'(cur.held_count);
      esc_end = {1'b0, cur.cursor_x} + 16'(b);
      dx_end = {1'b0, cur.cursor_x} + 16'(cur.held_dx);
      ylim = (cur.cursor_y < height_i) ? cur.cursor_y : height_i;
      dy_end = {1'b0, ylim} + 16'(b);
      b_plus = {1'b0, b} + 9'd1;
      abs_n = (cur.pixels_left >= 8'd2) ? 2'd2 : 2'd1;

      if (bad_geom) begin
         is_bounds = 1'b1;
      end else begin
         case (cur.phase)
            bmprle4_pkg::PH_VALUE: begin
               if (cur.held_count != '0) begin
                  if (y_out || (run_end > {1'b0, width_i})) begin
                     is_bounds = 1'b1;
                  end else begin
                     is_span = 1'b1;
                     span_len = cur.held_count;
                     nxt.cursor_x = run_end[14:0];
                     nxt.phase = bmprle4_pkg::PH_COUNT;
                  end
               end else if (b == 8'd0) begin
                  nxt.cursor_x = '0;
                  if (!y_out) begin
                     nxt.cursor_y = cur.cursor_y + 15'd1;
                  end
                  nxt.phase = bmprle4_pkg::PH_COUNT;
               end else if (b == 8'd1) begin
                  is_end = 1'b1;
                  nxt.phase = bmprle4_pkg::PH_COUNT;
               end else if (b == 8'd2) begin
                  nxt.phase = bmprle4_pkg::PH_DX;
               end else begin
                  if (y_out || (esc_end > {1'b0, width_i})) begin
                     is_bounds = 1'b1;
                  end else begin
                     nxt.pixels_left = b;
                     nxt.pad_pending = b_plus[1];
                     nxt.phase = bmprle4_pkg::PH_ABS;
                  end
               end
            end
            bmprle4_pkg::PH_DX: begin
               nxt.held_dx = b;
               nxt.phase = bmprle4_pkg::PH_DY;
            end
            bmprle4_pkg::PH_DY: begin
               if ((dx_end > {1'b0, width_i}) || (dy_end > {1'b0, height_i})) begin
                  is_bounds = 1'b1;
               end else begin
                  nxt.cursor_x = dx_end[14:0];
                  nxt.cursor_y = cur.cursor_y + 15'(b);
                  nxt.phase = bmprle4_pkg::PH_COUNT;
               end
            end
            bmprle4_pkg::PH_ABS: begin
               is_span = 1'b1;
               span_len = 8'(abs_n);
               nxt.cursor_x = cur.cursor_x + 15'(abs_n);
               nxt.pixels_left = (cur.pixels_left > 8'(abs_n)) ?
                                 cur.pixels_left - 8'(abs_n) : 8'd0;
               if (nxt.pixels_left == '0) begin
                  nxt.phase = cur.pad_pending ? bmprle4_pkg::PH_PAD
                                              : bmprle4_pkg::PH_COUNT;
               end
            end
            bmprle4_pkg::PH_PAD: begin
               nxt.pad_pending = 1'b0;
               nxt.phase = bmprle4_pkg::PH_COUNT;
            end
            default: begin
               nxt.held_count = b;
               nxt.phase = bmprle4_pkg::PH_VALUE;
            end
         endcase
      end

      res_valid_o = 1'b0;
      res_o = '0;
      res_o.result_kind = bmprle4_pkg::KIND_SPAN;
      if (cur.stopped) begin
         state_o = cur;
      end else begin
         state_o = nxt;
         if (is_bounds || is_end) begin
            res_valid_o = 1'b1;
            res_o.result_kind = is_bounds ? bmprle4_pkg::KIND_BOUNDS
                                          : bmprle4_pkg::KIND_END;
            state_o.stopped = 1'b1;
         end else if (item_i.in_last) begin
            res_valid_o = 1'b1;
            res_o.result_kind = bmprle4_pkg::KIND_TRUNC;
            state_o.stopped = 1'b1;
         end else if (is_span) begin
            res_valid_o = 1'b1;
            res_o.span_x = cur.cursor_x[bmprle4_pkg::SPAN_W-1:0];
            res_o.span_y = cur.cursor_y[bmprle4_pkg::SPAN_W-1:0];
            res_o.span_length = span_len;
            res_o.even_nibble = b[7:4];
            res_o.odd_nibble = b[3:0];
         end
      end
   end

endmodule
`default_nettype wire

>>> design/bmprle4_out_reg.sv
`default_nettype none
module bmprle4_out_reg (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        load_i,
   input  wire logic                        res_valid_i,
   input  wire bmprle4_pkg::rsp_item_type   res_i,
   output logic                             ready_o,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output bmprle4_pkg::rsp_item_type        rsp_item
);

   logic                      valid_ff;
   logic                      valid_in;
   bmprle4_pkg::rsp_item_type item_ff;

   assign ready_o = !valid_ff || rsp_ready;

   always_comb begin
      if (load_i) begin
         valid_in = res_valid_i;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_i && res_valid_i) begin
         item_ff <= res_i;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item = item_ff;

endmodule
`default_nettype wire

>>> design/bmp_rle4_span_decoder_core.sv
// channel   dir   handshake              payload
// req       in    req_valid/req_ready    req_item  (in_byte, in_first, in_last)
// rsp       out   rsp_valid/rsp_ready    rsp_item  (kind, x, y, length, nibbles)
// csr       in    csr_wr_en              csr_index, csr_wdata
//
// one item per cycle while req_ready is high; each accepted item updates the parser state in the same
// cycle and its result, if any, shows on rsp in the next cycle from the output register
// the output register is the only stage: req_ready drops only while a result waits
// and rsp_ready is low
// synchronous reset clears parser state, result valid and sets width and height to 16
`default_nettype none
module bmp_rle4_span_decoder_core #(
   parameter int MAX_SIDE = 16384
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_ready,
   input  wire bmprle4_pkg::req_item_type                 req_item,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_ready,
   output bmprle4_pkg::rsp_item_type                      rsp_item,
   input  wire logic                                      csr_wr_en,
   input  wire logic [bmprle4_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [bmprle4_pkg::CFG_WIDTH-1:0]         csr_wdata
);

   bmprle4_pkg::state_type                state_ff;
   bmprle4_pkg::state_type                state_in;
   logic [bmprle4_pkg::CFG_WIDTH-1:0]     width_ff;
   logic [bmprle4_pkg::CFG_WIDTH-1:0]     height_ff;
   logic                                  accept;
   logic                                  res_valid;
   bmprle4_pkg::rsp_item_type             res;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= bmprle4_pkg::WIDTH_RESET;
         height_ff <= bmprle4_pkg::HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            bmprle4_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata;
            end
            bmprle4_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   bmprle4_step #(
      .MAX_SIDE(MAX_SIDE)
   ) u_step (
      .state_i     (state_ff),
      .width_i     (width_ff),
      .height_i    (height_ff),
      .item_i      (req_item),
      .state_o     (state_in),
      .res_valid_o (res_valid),
      .res_o       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmprle4_pkg::STATE_RESET;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   bmprle4_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load_i      (accept),
      .res_valid_i (res_valid),
      .res_i       (res),
      .ready_o     (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item)
   );

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output register");

   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      accept && state_ff.stopped && !req_item.in_first |=> !rsp_valid)
      else $error("result produced while stopped");

   a_marker_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.result_kind != bmprle4_pkg::KIND_SPAN)
      |-> (rsp_item.span_length == '0) && (rsp_item.span_x == '0))
      else $error("marker result carries span fields");

   a_span_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.result_kind == bmprle4_pkg::KIND_SPAN)
      |-> (rsp_item.span_length != '0))
      else $error("empty span written");

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff.cursor_x <= 15'(MAX_SIDE)) && (state_ff.cursor_y <= 15'(MAX_SIDE)))
      else $error("cursor beyond maximum side");

endmodule
`default_nettype wire

>>> tb/sv/bmp_rle4_span_checker.sv
`timescale 1ns / 1ps
module bmp_rle4_span_checker #(
   parameter int MAX_SIDE = 16384
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  bmprle4_pkg::req_item_type             req_item,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  bmprle4_pkg::rsp_item_type             rsp_item,
   input  logic                                  csr_wr_en,
   input  logic [bmprle4_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bmprle4_pkg::CFG_WIDTH-1:0]     csr_wdata,
   output int                                    mismatches,
   output int                                    outstanding,
   output int                                    spans_seen,
   output int                                    ends_seen,
   output int                                    faults_seen
);

   logic [bmprle4_pkg::CFG_WIDTH-1:0] cfg_w, cfg_h;

   bmprle4_pkg::phase_type          phase;
   logic [bmprle4_pkg::COORD_W-1:0] col, row;
   logic [7:0]                      run_len, abs_left, dx_hold;
   logic                            pad_due, halted;

   bmprle4_pkg::rsp_item_type decoded_q[$];
   bmprle4_pkg::rsp_item_type predicted;
   logic                      predicted_valid;
   int                        n_bad, n_span, n_end, n_fault;

   task automatic clear_parser();
      phase    = bmprle4_pkg::PH_COUNT;
      col      = '0;
      row      = '0;
      run_len  = '0;
      abs_left = '0;
      dx_hold  = '0;
      pad_due  = 1'b0;
      halted   = 1'b0;
   endtask

   task automatic decode_byte(input bmprle4_pkg::req_item_type it, output logic emits,
                              output bmprle4_pkg::rsp_item_type r);
      int                    w, h, b, n, row_cap;
      logic                  span_made, halt_now;
      bmprle4_pkg::kind_type halt_kind;
      w         = int'(cfg_w);
      h         = int'(cfg_h);
      b         = int'(it.in_byte);
      emits     = 1'b0;
      r         = '0;
      span_made = 1'b0;
      halt_now  = 1'b0;
      halt_kind = bmprle4_pkg::KIND_BOUNDS;
      if (it.in_first) clear_parser();
      if (!halted) begin
         if (w == 0 || h == 0 || w > MAX_SIDE || h > MAX_SIDE) begin
            halt_now = 1'b1;
         end else begin
            case (phase)
               bmprle4_pkg::PH_VALUE: begin
                  if (run_len != 0) begin
                     if (row >= h || col + run_len > w) begin
                        halt_now = 1'b1;
                     end else begin
                        span_made     = 1'b1;
                        r.span_x      = col[bmprle4_pkg::SPAN_W-1:0];
                        r.span_y      = row[bmprle4_pkg::SPAN_W-1:0];
                        r.span_length = run_len;
                        r.even_nibble = it.in_byte[7:4];
                        r.odd_nibble  = it.in_byte[3:0];
                        col           = col + run_len;
                        phase         = bmprle4_pkg::PH_COUNT;
                     end
                  end else if (b == 0) begin
                     col = '0;
                     if (row < h) row = row + 1'b1;
                     phase = bmprle4_pkg::PH_COUNT;
                  end else if (b == 1) begin
                     halt_now  = 1'b1;
                     halt_kind = bmprle4_pkg::KIND_END;
                     phase     = bmprle4_pkg::PH_COUNT;
                  end else if (b == 2) begin
                     phase = bmprle4_pkg::PH_DX;
                  end else if (row >= h || col + b > w) begin
                     halt_now = 1'b1;
                  end else begin
                     abs_left = it.in_byte;
                     pad_due  = 1'(((b + 1) >> 1) & 1);
                     phase    = bmprle4_pkg::PH_ABS;
                  end
               end
               bmprle4_pkg::PH_DX: begin
                  dx_hold = it.in_byte;
                  phase   = bmprle4_pkg::PH_DY;
               end
               bmprle4_pkg::PH_DY: begin
                  row_cap = (row < h) ? int'(row) : h;
                  if (col + dx_hold > w || row_cap + b > h) begin
                     halt_now = 1'b1;
                  end else begin
                     col   = col + dx_hold;
                     row   = row + it.in_byte;
                     phase = bmprle4_pkg::PH_COUNT;
                  end
               end
               bmprle4_pkg::PH_ABS: begin
                  n             = (abs_left >= 2) ? 2 : 1;
                  span_made     = 1'b1;
                  r.span_x      = col[bmprle4_pkg::SPAN_W-1:0];
                  r.span_y      = row[bmprle4_pkg::SPAN_W-1:0];
                  r.span_length = 8'(n);
                  r.even_nibble = it.in_byte[7:4];
                  r.odd_nibble  = it.in_byte[3:0];
                  col           = col + 15'(n);
                  abs_left      = (abs_left > n) ? 8'(abs_left - n) : 8'd0;
                  if (abs_left == 0)
                     phase = pad_due ? bmprle4_pkg::PH_PAD : bmprle4_pkg::PH_COUNT;
               end
               bmprle4_pkg::PH_PAD: begin
                  pad_due = 1'b0;
                  phase   = bmprle4_pkg::PH_COUNT;
               end
               default: begin
                  run_len = it.in_byte;
                  phase   = bmprle4_pkg::PH_VALUE;
               end
            endcase
         end
         if (halt_now) begin
            halted        = 1'b1;
            emits         = 1'b1;
            r             = '0;
            r.result_kind = halt_kind;
         end else if (it.in_last) begin
            halted        = 1'b1;
            emits         = 1'b1;
            r             = '0;
            r.result_kind = bmprle4_pkg::KIND_TRUNC;
         end else if (span_made) begin
            emits         = 1'b1;
            r.result_kind = bmprle4_pkg::KIND_SPAN;
         end
      end
   endtask

   task automatic check_result(input bmprle4_pkg::rsp_item_type got);
      bmprle4_pkg::rsp_item_type want;
      if (decoded_q.size() == 0) begin
         n_bad++;
         if (n_bad <= 10)
            $display("%0t: result with nothing pending: kind %0d x %0d y %0d len %0d",
                     $time, got.result_kind, got.span_x, got.span_y, got.span_length);
      end else begin
         want = decoded_q.pop_front();
         if (got.result_kind !== want.result_kind || got.span_x !== want.span_x ||
             got.span_y !== want.span_y || got.span_length !== want.span_length ||
             got.even_nibble !== want.even_nibble ||
             got.odd_nibble !== want.odd_nibble) begin
            n_bad++;
            if (n_bad <= 10)
               $display({"%0t: result mismatch: expected kind %0d x %0d y %0d len %0d ",
                         "nib %h/%h, got kind %0d x %0d y %0d len %0d nib %h/%h"},
                        $time, want.result_kind, want.span_x, want.span_y,
                        want.span_length, want.even_nibble, want.odd_nibble,
                        got.result_kind, got.span_x, got.span_y, got.span_length,
                        got.even_nibble, got.odd_nibble);
         end
         case (want.result_kind)
            bmprle4_pkg::KIND_SPAN: n_span++;
            bmprle4_pkg::KIND_END:  n_end++;
            default:                n_fault++;
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_w = bmprle4_pkg::WIDTH_RESET;
         cfg_h = bmprle4_pkg::HEIGHT_RESET;
         clear_parser();
         decoded_q.delete();
         n_bad   = 0;
         n_span  = 0;
         n_end   = 0;
         n_fault = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_item);
         if (req_valid && req_ready) begin
            decode_byte(req_item, predicted_valid, predicted);
            if (predicted_valid) decoded_q = {decoded_q, predicted};
         end
         if (csr_wr_en) begin
            if (csr_index == bmprle4_pkg::CSR_IMAGE_WIDTH) cfg_w = csr_wdata;
            else if (csr_index == bmprle4_pkg::CSR_IMAGE_HEIGHT) cfg_h = csr_wdata;
         end
      end
      mismatches  <= n_bad;
      outstanding <= decoded_q.size();
      spans_seen  <= n_span;
      ends_seen   <= n_end;
      faults_seen <= n_fault;
   end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

   localparam int MAX_SIDE    = 16384;
   localparam int STALL_LIMIT = 2000;
   localparam logic [bmprle4_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                              clock;
   logic                              reset;
   logic                              req_valid, req_ready;
   bmprle4_pkg::req_item_type         req_item;
   logic                              rsp_valid, rsp_ready;
   bmprle4_pkg::rsp_item_type         rsp_item;
   logic                              csr_wr_en;
   logic [bmprle4_pkg::CSR_IDX_W-1:0] csr_index;
   logic [bmprle4_pkg::CFG_WIDTH-1:0] csr_wdata;

   int mismatches, outstanding, spans_seen, ends_seen, faults_seen;

   int   stall_cycles = 0;
   int   n_items, n_bitmaps, n_geoms, req_calm, rsp_calm;
   int   cur_w, cur_h, gx, gy, bm_bytes, cut_at;
   logic pend_first, dead;

   bmp_rle4_span_decoder_core #(.MAX_SIDE(MAX_SIDE)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bmp_rle4_span_checker #(.MAX_SIDE(MAX_SIDE)) span_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .spans_seen  (spans_seen),
      .ends_seen   (ends_seen),
      .faults_seen (faults_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("[bmp_rle4_span_decoder_core] ERROR");
         $finish;
      end
   end

   function automatic int lesser(input int a, input int b);
      return (a < b) ? a : b;
   endfunction

   // random wait, with occasional stretches of back-to-back traffic
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) calm = $urandom_range(16, 64);
      return $urandom_range(0, 4);
   endfunction

   function automatic int pick_count(input int lo, input int room);
      int hi;
      hi = lesser(room, 255);
      if ($urandom_range(0, 3) == 0) return $urandom_range(lo, hi);
      return $urandom_range(lo, lesser(hi, lo + 13));
   endfunction

   initial begin
      int stall;
      rsp_ready <= 1'b0;
      rsp_calm = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(rsp_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
      int gap;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= {b, first, last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic emit(input logic [7:0] b, input logic last);
      logic cut;
      if (!dead) begin
         cut = last || (bm_bytes == cut_at);
         send_byte(b, pend_first, cut);
         pend_first = 1'b0;
         bm_bytes++;
         n_items++;
         if (cut) dead = 1'b1;
      end
   endtask

   task automatic start_bitmap(input int cut);
      pend_first = 1'b1;
      dead       = 1'b0;
      gx         = 0;
      gy         = 0;
      bm_bytes   = 0;
      cut_at     = cut;
      n_bitmaps++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_geometry(input int w, input int h);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SPARE;
      csr_wdata <= 15'($urandom);
      @(posedge clock);
      csr_index <= bmprle4_pkg::CSR_IMAGE_WIDTH;
      csr_wdata <= 15'(w);
      @(posedge clock);
      csr_index <= bmprle4_pkg::CSR_IMAGE_HEIGHT;
      csr_wdata <= 15'(h);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_w = w;
      cur_h = h;
      n_geoms++;
   endtask

   task automatic gen_bitmap();
      int n_ops, room, rows_left, cnt, dx, dy, r;
      if ($urandom_range(0, 7) == 0) start_bitmap($urandom_range(0, 40));
      else start_bitmap(-1);
      if (cur_w < 1 || cur_w > MAX_SIDE || cur_h < 1 || cur_h > MAX_SIDE ||
          $urandom_range(0, 11) == 0) begin
         repeat ($urandom_range(1, 12)) emit(8'($urandom), $urandom_range(0, 7) == 0);
      end else begin
         n_ops = $urandom_range(1, 24);
         for (int i = 0; i < n_ops && !dead; i++) begin
            room      = cur_w - gx;
            rows_left = cur_h - lesser(gy, cur_h);
            r         = $urandom_range(0, 15);
            if (r <= 6 && gy < cur_h && room >= 1) begin
               cnt = pick_count(1, room);
               emit(8'(cnt), 1'b0);
               emit(8'($urandom), 1'b0);
               gx += cnt;
            end else if (r <= 9 && gy < cur_h && room >= 3) begin
               cnt = pick_count(3, room);
               emit(8'h00, 1'b0);
               emit(8'(cnt), 1'b0);
               repeat ((cnt + 1) / 2) emit(8'($urandom), 1'b0);
               if (((cnt + 1) / 2) % 2 == 1) emit(8'($urandom), 1'b0);
               gx += cnt;
            end else if (r <= 12) begin
               dx = $urandom_range(0, lesser(room, 255));
               dy = $urandom_range(0, lesser(rows_left, 255));
               emit(8'h00, 1'b0);
               emit(8'h02, 1'b0);
               emit(8'(dx), 1'b0);
               emit(8'(dy), 1'b0);
               gx += dx;
               gy += dy;
            end else if (r <= 14) begin
               emit(8'h00, 1'b0);
               emit(8'h00, 1'b0);
               gx = 0;
               if (gy < cur_h) gy++;
            end else begin
               // out-of-bounds run or delta if one fits in a byte; ends the bitmap either way
               if (gy >= cur_h || room < 255) begin
                  cnt = (gy >= cur_h) ? $urandom_range(3, 255) : room + 1;
                  if (cnt >= 3 && $urandom_range(0, 1) == 1) begin
                     emit(8'h00, 1'b0);
                     emit(8'(cnt), 1'b0);
                  end else begin
                     emit(8'(cnt), 1'b0);
                     emit(8'($urandom), 1'b0);
                  end
               end else if (rows_left < 255) begin
                  emit(8'h00, 1'b0);
                  emit(8'h02, 1'b0);
                  emit(8'h00, 1'b0);
                  emit(8'(rows_left + 1), 1'b0);
               end
               dead = 1'b1;
            end
         end
         if ($urandom_range(0, 15) != 0) begin
            emit(8'h00, 1'b0);
            emit(8'h01, $urandom_range(0, 1) == 1);
         end
      end
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3))
            send_byte(8'($urandom), 1'b0, $urandom_range(0, 1) == 1);
   endtask

   task automatic run_bitmaps(input int budget);
      int start;
      start = n_items;
      while (n_items - start < budget) gen_bitmap();
   endtask

   initial begin
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_item   <= '0;
      csr_wr_en  <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      n_items    = 0;
      n_bitmaps  = 0;
      n_geoms    = 0;
      req_calm   = 0;
      cur_w      = int'(bmprle4_pkg::WIDTH_RESET);
      cur_h      = int'(bmprle4_pkg::HEIGHT_RESET);
      pend_first = 1'b0;
      dead       = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // full-width run, end of line, delta, padded absolute run, run past the right edge
      start_bitmap(-1);
      emit(8'd16, 1'b0);
      emit(8'hF0, 1'b0);
      emit(8'h00, 1'b0);
      emit(8'h00, 1'b0);
      emit(8'h00, 1'b0);
      emit(8'h02, 1'b0);
      emit(8'd16, 1'b0);
      emit(8'd2, 1'b0);
      emit(8'h00, 1'b0);
      emit(8'h00, 1'b0);
      emit(8'h00, 1'b0);
      emit(8'd5, 1'b0);
      emit(8'hAB, 1'b0);
      emit(8'hCD, 1'b0);
      emit(8'hE0, 1'b0);
      emit(8'h00, 1'b0);
      emit(8'd12, 1'b0);
      emit(8'h5A, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b1);
      // delta past the top
      start_bitmap(-1);
      emit(8'h00, 1'b0);
      emit(8'h02, 1'b0);
      emit(8'h00, 1'b0);
      emit(8'd17, 1'b0);
      // last byte on a span
      start_bitmap(-1);
      emit(8'd2, 1'b0);
      emit(8'h77, 1'b1);
      start_bitmap(-1);
      emit(8'h00, 1'b0);
      emit(8'h01, 1'b1);
      run_bitmaps(250);

      // end of line on the last row
      set_geometry(1, 1);
      start_bitmap(-1);
      emit(8'h00, 1'b0);
      emit(8'h00, 1'b0);
      emit(8'h00, 1'b0);
      emit(8'h00, 1'b0);
      emit(8'h00, 1'b0);
      emit(8'h01, 1'b1);
      run_bitmaps(80);

      set_geometry(MAX_SIDE, MAX_SIDE);
      run_bitmaps(300);
      set_geometry(0, 16);
      run_bitmaps(4);
      set_geometry(16, 0);
      run_bitmaps(4);
      set_geometry(MAX_SIDE + 1, MAX_SIDE);
      run_bitmaps(4);
      set_geometry(32767, 32767);
      run_bitmaps(4);
      set_geometry(MAX_SIDE, 1);
      run_bitmaps(100);
      set_geometry(1, MAX_SIDE);
      run_bitmaps(100);
      set_geometry(2, 3);
      run_bitmaps(60);
      for (int p = 0; p < 4; p++) begin
         set_geometry($urandom_range(1, 600), $urandom_range(1, 64));
         run_bitmaps(110);
      end

      wait_idle();
      $display("covered %0d bitmaps in %0d stream bytes across %0d size settings",
               n_bitmaps, n_items, n_geoms);
      $display("checked %0d spans, %0d end markers, %0d error or truncation results",
               spans_seen, ends_seen, faults_seen);
      if (mismatches == 0)
         $display("[bmp_rle4_span_decoder_core] OK");
      else
         $display("[bmp_rle4_span_decoder_core] ERROR");
      $finish;
   end

endmodule
